// ===== rtl/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/e2dy_pkg.sv =====
// shared constants and helpers of the epoch to decimal year unit
package e2dy_pkg;

  // default input time width and quotient bits resolved per divider stage
  localparam int E2DY_TIME_BITS = 36;
  localparam int E2DY_DIV_STEPS = 4;

  // field widths
  localparam int DIGITS_W = 4;
  localparam int OFFSET_W = 17;
  localparam int YEAR_W   = 13;
  localparam int FRAC_W   = 30;
  localparam int OUT_W    = 48;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_DIGITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UTC_OFFSET      = 1'd1;

  localparam logic [DIGITS_W-1:0] FRAC_DIGITS_RESET = 4'd2;

  // seconds from 1600-01-01 to 1970-01-01
  localparam logic [63:0] BASE_1600_SECS = 64'd11676096000;

  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [17:0] DAYS_PER_CYCLE = 18'd146097;
  localparam logic [10:0] DAYS_PER_QUAD  = 11'd1461;
  localparam logic [24:0] SECS_LEAP_YEAR   = 25'd31622400;
  localparam logic [24:0] SECS_COMMON_YEAR = 25'd31536000;
  localparam logic [YEAR_W-1:0] CYCLE_BASE_YEAR = 13'd1600;
  localparam logic [YEAR_W-1:0] YEARS_PER_CYCLE = 13'd400;
  localparam logic [29:0] FRAC_LIMIT = 30'd1000000000;

  // first day of each century inside a 400-year cycle (the first one is 36525 days)
  localparam logic [17:0] CENT1_DAY = 18'd36525;
  localparam logic [17:0] CENT2_DAY = 18'd73049;
  localparam logic [17:0] CENT3_DAY = 18'd109573;

  // first day of each year inside a four-year group that opens with a leap year
  localparam logic [10:0] QYEAR1_DAY = 11'd366;
  localparam logic [10:0] QYEAR2_DAY = 11'd731;
  localparam logic [10:0] QYEAR3_DAY = 11'd1096;

  // ten to the given digit count, counts above nine saturate
  function automatic logic [FRAC_W-1:0] pow10(input logic [DIGITS_W-1:0] d);
    logic [FRAC_W-1:0] p;
    case (d)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      default: p = 30'd1000000000;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/e2dy_div.sv =====
// pipelined restoring divider, a few quotient bits per stage, with tag sideband
module e2dy_div
  import e2dy_pkg::*;
#(
  parameter int NUM_W = 16,
  parameter int DEN_W = 11,
  parameter int TAG_W = 1,
  parameter int STEPS = E2DY_DIV_STEPS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int NSTG  = (NUM_W + STEPS - 1) / STEPS;
  localparam int WRK_W = NSTG * STEPS;

  logic             vld_r [NSTG];
  logic [DEN_W-1:0] rem_r [NSTG];
  logic [DEN_W-1:0] den_r [NSTG];
  logic [WRK_W-1:0] wrk_r [NSTG];
  logic [TAG_W-1:0] tag_r [NSTG];

  for (genvar k = 0; k < NSTG; k++) begin : g_stg
    logic             stg_vld;
    logic [DEN_W-1:0] stg_rem;
    logic [DEN_W-1:0] stg_den;
    logic [WRK_W-1:0] stg_wrk;
    logic [TAG_W-1:0] stg_tag;
    logic [DEN_W-1:0] rem_nxt;
    logic [WRK_W-1:0] wrk_nxt;

    if (k == 0) begin : g_head
      assign stg_vld = vld_i;
      assign stg_rem = '0;
      assign stg_den = den_i;
      assign stg_wrk = WRK_W'(num_i);
      assign stg_tag = tag_i;
    end else begin : g_body
      assign stg_vld = vld_r[k-1];
      assign stg_rem = rem_r[k-1];
      assign stg_den = den_r[k-1];
      assign stg_wrk = wrk_r[k-1];
      assign stg_tag = tag_r[k-1];
    end

    // dividend bits leave at the top, quotient bits enter at the bottom
    always_comb begin
      logic [DEN_W:0]   part;
      logic [DEN_W-1:0] rem_v;
      logic [WRK_W-1:0] wrk_v;
      rem_v = stg_rem;
      wrk_v = stg_wrk;
      for (int b = 0; b < STEPS; b++) begin
        part  = {rem_v, wrk_v[WRK_W-1]};
        wrk_v = {wrk_v[WRK_W-2:0], 1'b0};
        if (part >= {1'b0, stg_den}) begin
          part     = part - {1'b0, stg_den};
          wrk_v[0] = 1'b1;
        end
        rem_v = part[DEN_W-1:0];
      end
      rem_nxt = rem_v;
      wrk_nxt = wrk_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= stg_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        den_r[k] <= stg_den;
        wrk_r[k] <= wrk_nxt;
        tag_r[k] <= stg_tag;
      end
    end
  end

  assign vld_o = vld_r[NSTG-1];
  assign quo_o = wrk_r[NSTG-1][NUM_W-1:0];
  assign rem_o = rem_r[NSTG-1];
  assign tag_o = tag_r[NSTG-1];

endmodule

// ===== rtl/epoch_to_decimal_year_unit.sv =====
// top level of the epoch to decimal year unit
//
// Converts a Unix time in seconds, shifted by a programmable UTC offset, into the local
// Gregorian year and the elapsed part of that year as floor(elapsed * 10^digits / yearlength).
// The unit takes one timestamp per clock cycle while in_tready is high and gives one result
// per timestamp, in order. Timestamps pass through four pipelined dividers (seconds to days,
// days to 400-year cycles, days to four-year groups, and the final fraction), each resolving
// S quotient bits per stage (S is DIV_STEPS). in_tready drops only when both the output
// register and the skid slot hold results; the whole pipeline then freezes. Configuration
// writes are taken at once (cfg_ready is always high) and must only be issued while the unit is
// empty. Digit counts above nine act as nine.
module epoch_to_decimal_year_unit
  import e2dy_pkg::*;
#(
  parameter int TIME_BITS = E2DY_TIME_BITS,
  parameter int DIV_STEPS = E2DY_DIV_STEPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [OFFSET_W-1:0]           cfg_data,
  // timestamp input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0] in_tdata,  // unix_seconds, zero padding
  // result output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata   // calendar_year, year_fraction, zero padding
);

  `include "assert_macros.svh"

  // local time counted from 1600-01-01 fits these bits (wraps mod 2^64 at the top)
  localparam int LOCAL_W = (TIME_BITS >= 63) ? 64 : ((TIME_BITS < 34) ? 35 : TIME_BITS + 1);
  localparam int DAY_W   = LOCAL_W - 16;
  localparam int CYC_W   = DAY_W - 17;
  localparam int PROD_W  = 55;

  // configuration registers
  logic [DIGITS_W-1:0] fd_r;
  logic [OFFSET_W-1:0] off_r;

  // pipeline advance, frozen only while the skid slot is full
  logic adv;

  // stage 0: local seconds
  logic               s0_v_r;
  logic [LOCAL_W-1:0] s0_local_r;
  logic [LOCAL_W-1:0] local_nxt;

  // seconds to days
  logic               a_vld;
  logic [LOCAL_W-1:0] a_quo;
  logic [16:0]        a_rem;

  // days to 400-year cycles
  logic               b_vld;
  logic [DAY_W-1:0]   b_quo;
  logic [17:0]        b_rem;
  logic [16:0]        b_secs;

  // stage 2: century split
  logic              s2_v_r;
  logic [1:0]        s2_cen_r;
  logic [15:0]       s2_docp_r;
  logic [YEAR_W-1:0] s2_yb_r;
  logic [16:0]       s2_secs_r;
  logic [1:0]        cen_nxt;
  logic [17:0]       cen_start;
  logic [17:0]       doc;
  logic [15:0]       docp_nxt;
  logic [YEAR_W-1:0] yb_nxt;

  // days in century to four-year groups
  logic              c_vld;
  logic [15:0]       c_quo;
  logic [10:0]       c_rem;
  logic [31:0]       c_tag;
  logic [4:0]        c_grp;
  logic [1:0]        c_cen;
  logic [16:0]       c_secs;
  logic [YEAR_W-1:0] c_yb;

  // stage 3: year and day of year
  logic              s3_v_r;
  logic [YEAR_W-1:0] s3_year_r;
  logic [8:0]        s3_doy_r;
  logic              s3_leap_r;
  logic [16:0]       s3_secs_r;
  logic [1:0]        qy;
  logic [10:0]       qy_start;
  logic              late_century;
  logic [10:0]       doy_full;
  logic [8:0]        yoe;
  logic [YEAR_W-1:0] year_nxt;
  logic              leap_nxt;

  // stage 4: elapsed seconds, scale and year length
  logic              s4_v_r;
  logic [24:0]       s4_el_r;
  logic [FRAC_W-1:0] s4_p10_r;
  logic [24:0]       s4_ylen_r;
  logic [YEAR_W-1:0] s4_year_r;
  logic [24:0]       el_nxt;

  // stage 5: scaled elapsed seconds
  logic              s5_v_r;
  logic [PROD_W-1:0] s5_prod_r;
  logic [24:0]       s5_ylen_r;
  logic [YEAR_W-1:0] s5_year_r;
  logic [PROD_W-1:0] prod_nxt;

  // final fraction divider
  logic              d_vld;
  logic [PROD_W-1:0] d_quo;
  logic [YEAR_W-1:0] d_year;

  // output register and skid slot
  logic              out_v_r;
  logic              skid_v_r;
  logic [YEAR_W-1:0] out_year_r;
  logic [FRAC_W-1:0] out_frac_r;
  logic [YEAR_W-1:0] skid_year_r;
  logic [FRAC_W-1:0] skid_frac_r;
  logic              out_v_nxt;
  logic              skid_v_nxt;

  // ---------------------------------------------------------------- configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_r  <= FRAC_DIGITS_RESET;
      off_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRACTION_DIGITS: fd_r  <= cfg_data[DIGITS_W-1:0];
        CFG_UTC_OFFSET:      off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  assign adv       = !skid_v_r;
  assign in_tready = adv;

  // seconds since 1600-01-01 in local time, never negative
  assign local_nxt = LOCAL_W'(in_tdata[TIME_BITS-1:0]) + LOCAL_W'(BASE_1600_SECS)
                   + {{(LOCAL_W-OFFSET_W){off_r[OFFSET_W-1]}}, off_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_local_r <= local_nxt;
    end
  end

  // ---------------------------------------------------------------- days and seconds of day
  e2dy_div #(
    .NUM_W (LOCAL_W),
    .DEN_W (17),
    .TAG_W (1),
    .STEPS (DIV_STEPS)
  ) u_div_day (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s0_v_r),
    .num_i (s0_local_r),
    .den_i (SECS_PER_DAY),
    .tag_i (1'b0),
    .vld_o (a_vld),
    .quo_o (a_quo),
    .rem_o (a_rem),
    .tag_o ()
  );

  // ---------------------------------------------------------------- 400-year cycles
  e2dy_div #(
    .NUM_W (DAY_W),
    .DEN_W (18),
    .TAG_W (17),
    .STEPS (DIV_STEPS)
  ) u_div_cycle (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (a_vld),
    .num_i (a_quo[DAY_W-1:0]),
    .den_i (DAYS_PER_CYCLE),
    .tag_i (a_rem),
    .vld_o (b_vld),
    .quo_o (b_quo),
    .rem_o (b_rem),
    .tag_o (b_secs)
  );

  // ---------------------------------------------------------------- stage 2: century
  // the first century of a cycle starts with a leap year and is one day longer
  always_comb begin
    cen_nxt = {1'b0, b_rem >= CENT1_DAY} + {1'b0, b_rem >= CENT2_DAY}
            + {1'b0, b_rem >= CENT3_DAY};
    case (cen_nxt)
      2'd0:    cen_start = '0;
      2'd1:    cen_start = CENT1_DAY;
      2'd2:    cen_start = CENT2_DAY;
      default: cen_start = CENT3_DAY;
    endcase
    doc = b_rem - cen_start;
    // later centuries lack the leap day of their first year, count as if present
    docp_nxt = doc[15:0] + {15'd0, cen_nxt != 2'd0};
    // only the low year bits are kept, so the cycle count wraps harmlessly
    yb_nxt = CYCLE_BASE_YEAR + YEAR_W'(YEAR_W'(b_quo[CYC_W-1:0]) * YEARS_PER_CYCLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cen_r  <= cen_nxt;
      s2_docp_r <= docp_nxt;
      s2_yb_r   <= yb_nxt;
      s2_secs_r <= b_secs;
    end
  end

  // ---------------------------------------------------------------- four-year groups
  e2dy_div #(
    .NUM_W (16),
    .DEN_W (11),
    .TAG_W (32),
    .STEPS (DIV_STEPS)
  ) u_div_quad (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s2_v_r),
    .num_i (s2_docp_r),
    .den_i (DAYS_PER_QUAD),
    .tag_i ({s2_yb_r, s2_cen_r, s2_secs_r}),
    .vld_o (c_vld),
    .quo_o (c_quo),
    .rem_o (c_rem),
    .tag_o (c_tag)
  );

  assign c_grp  = c_quo[4:0];
  assign c_secs = c_tag[16:0];
  assign c_cen  = c_tag[18:17];
  assign c_yb   = c_tag[31:19];

  // ---------------------------------------------------------------- stage 3: year
  always_comb begin
    qy = {1'b0, c_rem >= QYEAR1_DAY} + {1'b0, c_rem >= QYEAR2_DAY}
       + {1'b0, c_rem >= QYEAR3_DAY};
    case (qy)
      2'd0:    qy_start = '0;
      2'd1:    qy_start = QYEAR1_DAY;
      2'd2:    qy_start = QYEAR2_DAY;
      default: qy_start = QYEAR3_DAY;
    endcase
    // first group of a later century: its first year is common, undo the extra day
    late_century = (c_cen != 2'd0) && (c_grp == 5'd0);
    doy_full = c_rem - qy_start - {10'd0, late_century && (qy == 2'd0)};
    leap_nxt = (qy == 2'd0) && !late_century;
    yoe      = 9'd100 * {7'd0, c_cen} + {2'd0, c_grp, 2'd0} + {7'd0, qy};
    year_nxt = c_yb + {4'd0, yoe};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_year_r <= year_nxt;
      s3_doy_r  <= doy_full[8:0];
      s3_leap_r <= leap_nxt;
      s3_secs_r <= c_secs;
    end
  end

  // ---------------------------------------------------------------- stage 4: elapsed seconds
  assign el_nxt = 25'(s3_doy_r) * 25'(SECS_PER_DAY) + {8'd0, s3_secs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_el_r   <= el_nxt;
      s4_p10_r  <= pow10(fd_r);
      s4_ylen_r <= s3_leap_r ? SECS_LEAP_YEAR : SECS_COMMON_YEAR;
      s4_year_r <= s3_year_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: scaling
  assign prod_nxt = {30'd0, s4_el_r} * {25'd0, s4_p10_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_prod_r <= prod_nxt;
      s5_ylen_r <= s4_ylen_r;
      s5_year_r <= s4_year_r;
    end
  end

  // ---------------------------------------------------------------- year fraction
  e2dy_div #(
    .NUM_W (PROD_W),
    .DEN_W (25),
    .TAG_W (YEAR_W),
    .STEPS (DIV_STEPS)
  ) u_div_frac (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s5_v_r),
    .num_i (s5_prod_r),
    .den_i (s5_ylen_r),
    .tag_i (s5_year_r),
    .vld_o (d_vld),
    .quo_o (d_quo),
    .rem_o (),
    .tag_o (d_year)
  );

  // ---------------------------------------------------------------- output and skid slot
  // a result leaving the pipeline goes to the skid slot only while the output waits
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    if (skid_v_r) begin
      if (out_tready) begin
        skid_v_nxt = 1'b0;
      end
    end else if (out_v_r && !out_tready) begin
      skid_v_nxt = d_vld;
    end else begin
      out_v_nxt = d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_tready) begin
        out_year_r <= skid_year_r;
        out_frac_r <= skid_frac_r;
      end
    end else if (out_v_r && !out_tready) begin
      skid_year_r <= d_year;
      skid_frac_r <= d_quo[FRAC_W-1:0];
    end else begin
      out_year_r <= d_year;
      out_frac_r <= d_quo[FRAC_W-1:0];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(OUT_W - YEAR_W - FRAC_W)'(0), out_frac_r, out_year_r};

  // ---------------------------------------------------------------- checks
  `ASSERT_RST(a_reset_empties, !rst_n |=> !out_v_r && !skid_v_r, "output side not empty after reset")
  `ASSERT_CLK(a_skid_behind_out, skid_v_r |-> out_v_r, "skid slot holds a result while output is empty")
  `ASSERT_CLK(a_common_year_days, s3_v_r && !s3_leap_r |-> s3_doy_r < 9'd365, "day 365 in a common year")
  `ASSERT_CLK(a_frac_range, d_vld |-> d_quo < PROD_W'(FRAC_LIMIT), "year fraction out of range")

endmodule
